FILE: rtl/ps2_scancode_to_char_translator_unit_macros.svh
// Assertion helpers for the scancode translator.
`ifndef PS2_SCANCODE_TO_CHAR_TRANSLATOR_UNIT_MACROS_SVH
`define PS2_SCANCODE_TO_CHAR_TRANSLATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PS2SC_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PS2SC_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

FILE: rtl/ps2sc_pkg.sv
`default_nettype none

package ps2sc_pkg;

  // Entries in each of the four translation tables.
  localparam int TABLE_ENTRIES = 256;
  localparam int TBL_IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int TBL_ADDR_W    = TBL_IDX_W + 2;
  localparam int TBL_DEPTH     = 4 * TABLE_ENTRIES;

  // Scancode set 2 codes.
  localparam logic [7:0] CODE_BREAK  = 8'hF0;
  localparam logic [7:0] CODE_EXTEND = 8'hE0;
  localparam logic [7:0] CODE_CTRL   = 8'h14;
  localparam logic [7:0] CODE_SHIFT  = 8'h59;
  localparam logic [7:0] CODE_NUM    = 8'h77;
  localparam logic [7:0] CODE_CAPS   = 8'h58;
  localparam logic [7:0] CODE_SCROLL = 8'h7E;
  localparam logic [7:0] CODE_ALT    = 8'h11;
  localparam logic [7:0] CODE_DEL    = 8'h71;

  // Modifier bits.
  localparam logic [2:0] MOD_SHIFT    = 3'b001;
  localparam logic [2:0] MOD_ALT      = 3'b010;
  localparam logic [2:0] MOD_CTRL     = 3'b100;
  localparam logic [2:0] MOD_CTRL_ALT = 3'b110;

  // Lock flag bits.
  localparam logic [2:0] LOCK_NUM    = 3'b001;
  localparam logic [2:0] LOCK_CAPS   = 3'b010;
  localparam logic [2:0] LOCK_SCROLL = 3'b100;

  // LED bits.
  localparam logic [2:0] LED_SCROLL = 3'b001;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_CAPS   = 3'b100;

  localparam logic MODE_SCAN  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef enum logic [1:0] {
    TBL_EXT   = 2'd0,
    TBL_CTRL  = 2'd1,
    TBL_SHIFT = 2'd2,
    TBL_PLAIN = 2'd3
  } tbl_sel_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] scan_byte;
    logic [1:0] table_select;
    logic [7:0] table_data;
  } in_item_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_code;
    logic [2:0] led_bits;
    logic       led_update;
    logic       reset_request;
  } out_item_t;

  // Table memory access for one transaction.
  typedef struct packed {
    logic                  en;
    logic                  we;
    logic [TBL_ADDR_W-1:0] addr;
    logic [7:0]            wdata;
  } mem_req_t;

  // Decoded outcome of one transaction, waiting for the table read.
  typedef struct packed {
    logic       char_valid;
    logic       lookup;
    logic [2:0] led_bits;
    logic       led_update;
    logic       reset_request;
  } dec_t;

endpackage

`default_nettype wire

FILE: rtl/ps2sc_table_ram.sv
`default_nettype none

module ps2sc_table_ram (
  input  wire logic               clk,
  input  wire ps2sc_pkg::mem_req_t req,
  output logic [7:0]              rdata
);

  logic [7:0] mem [ps2sc_pkg::TBL_DEPTH];

  // Read data holds while the port is idle.
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end
      rdata <= mem[req.addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ps2sc_key_decode.sv
`default_nettype none

module ps2sc_key_decode (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire ps2sc_pkg::in_item_t item,
  output ps2sc_pkg::dec_t          dec,
  output ps2sc_pkg::mem_req_t      mem_req
);

  logic       brk, brk_next;
  logic       ext, ext_next;
  logic [2:0] mods, mods_next;
  logic [2:0] locks, locks_next;
  logic [2:0] leds, leds_next;
  logic [2:0] mod_mask, lock_mask, led_mask;
  logic       is_mod, is_lock, in_range, char_valid;
  ps2sc_pkg::tbl_sel_t sel;

  assign in_range = {1'b0, item.scan_byte} < 9'(ps2sc_pkg::TABLE_ENTRIES);

  // Classify modifier and lock keys.
  always_comb begin
    mod_mask  = '0;
    lock_mask = '0;
    led_mask  = '0;
    is_mod    = 1'b0;
    is_lock   = 1'b0;
    case (item.scan_byte)
      ps2sc_pkg::CODE_CTRL: begin
        is_mod   = 1'b1;
        mod_mask = ps2sc_pkg::MOD_CTRL;
      end
      ps2sc_pkg::CODE_SHIFT: begin
        is_mod   = 1'b1;
        mod_mask = ps2sc_pkg::MOD_SHIFT;
      end
      ps2sc_pkg::CODE_ALT: begin
        is_mod   = 1'b1;
        mod_mask = ps2sc_pkg::MOD_ALT;
      end
      ps2sc_pkg::CODE_NUM: begin
        is_lock   = 1'b1;
        lock_mask = ps2sc_pkg::LOCK_NUM;
        led_mask  = ps2sc_pkg::LED_NUM;
      end
      ps2sc_pkg::CODE_CAPS: begin
        is_lock   = 1'b1;
        lock_mask = ps2sc_pkg::LOCK_CAPS;
        led_mask  = ps2sc_pkg::LED_CAPS;
      end
      ps2sc_pkg::CODE_SCROLL: begin
        is_lock   = 1'b1;
        lock_mask = ps2sc_pkg::LOCK_SCROLL;
        led_mask  = ps2sc_pkg::LED_SCROLL;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    brk_next          = brk;
    ext_next          = ext;
    mods_next         = mods;
    locks_next        = locks;
    leds_next         = leds;
    char_valid        = 1'b0;
    dec.led_update    = 1'b0;
    dec.reset_request = 1'b0;
    sel               = ps2sc_pkg::TBL_PLAIN;
    if (item.mode == ps2sc_pkg::MODE_WRITE) begin
      // Table write: flags untouched.
    end else if (item.scan_byte == ps2sc_pkg::CODE_BREAK) begin
      brk_next = 1'b1;
    end else if (item.scan_byte == ps2sc_pkg::CODE_EXTEND) begin
      ext_next = 1'b1;
    end else if (is_mod) begin
      mods_next = brk ? (mods & ~mod_mask) : (mods | mod_mask);
      brk_next  = 1'b0;
    end else if (is_lock) begin
      if (brk) begin
        brk_next = 1'b0;
      end else begin
        locks_next     = locks ^ lock_mask;
        leds_next      = leds ^ led_mask;
        dec.led_update = 1'b1;
      end
    end else if (brk) begin
      brk_next = 1'b0;
    end else if ((mods & ps2sc_pkg::MOD_CTRL_ALT) == ps2sc_pkg::MOD_CTRL_ALT &&
                 item.scan_byte == ps2sc_pkg::CODE_DEL) begin
      dec.reset_request = 1'b1;
      ext_next          = 1'b0;
    end else if (ext) begin
      ext_next   = 1'b0;
      char_valid = 1'b1;
      sel        = ps2sc_pkg::TBL_EXT;
    end else if ((mods & ps2sc_pkg::MOD_CTRL) != 3'b000) begin
      char_valid = 1'b1;
      sel        = ps2sc_pkg::TBL_CTRL;
    end else if ((mods & ps2sc_pkg::MOD_SHIFT) != 3'b000) begin
      char_valid = 1'b1;
      sel        = ps2sc_pkg::TBL_SHIFT;
    end else begin
      char_valid = 1'b1;
    end
    dec.char_valid = char_valid;
    dec.lookup     = char_valid && in_range;
    dec.led_bits   = leds_next;
  end

  // One table port: write on table items, read on every scancode item.
  always_comb begin
    mem_req.en    = fire;
    mem_req.we    = item.mode == ps2sc_pkg::MODE_WRITE && in_range;
    mem_req.wdata = item.table_data;
    if (item.mode == ps2sc_pkg::MODE_WRITE) begin
      mem_req.addr = {item.table_select, item.scan_byte[ps2sc_pkg::TBL_IDX_W-1:0]};
    end else begin
      mem_req.addr = {sel, item.scan_byte[ps2sc_pkg::TBL_IDX_W-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      brk   <= 1'b0;
      ext   <= 1'b0;
      mods  <= '0;
      locks <= '0;
      leds  <= '0;
    end else if (fire) begin
      brk   <= brk_next;
      ext   <= ext_next;
      mods  <= mods_next;
      locks <= locks_next;
      leds  <= leds_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ps2_scancode_to_char_translator_unit.sv
// Pipeline: the accepting edge loads stage 1 and starts the table read; when
//   stage 1 advances, it loads the output register, from which the result
//   is taken.
// Throughput: one transaction per cycle while results are taken; the table
//   memory port serves one write or one read per transaction, with a registered read.
// Reset: rst clears break/extend/modifier/lock/LED state and the pipeline;
//   the translation tables are not cleared and must be loaded before use.
`default_nettype none

`include "ps2_scancode_to_char_translator_unit_macros.svh"

module ps2_scancode_to_char_translator_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ps2sc_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ps2sc_pkg::out_item_t      out_item
);

  logic                in_fire;
  logic                s1_valid;
  logic                s1_adv;
  ps2sc_pkg::dec_t     dec;
  ps2sc_pkg::dec_t     s1_dec;
  ps2sc_pkg::mem_req_t mem_req;
  logic [7:0]          rdata;

  // Stage 1 holds a transaction while its table read completes. It advances
  // into the output register whenever that register is empty or being taken,
  // so a new transaction enters in the same cycle the old one leaves.
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // Decode flags and issue the table access at acceptance.
  ps2sc_key_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .fire    (in_fire),
    .item    (in_item),
    .dec     (dec),
    .mem_req (mem_req)
  );

  // Read data is only refreshed on acceptance, so it holds while stage 1
  // stalls; a write and a later read of one entry never share a cycle.
  ps2sc_table_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_dec <= dec;
    end
  end

  // Output register: merge the decoded outcome with the table data.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item.char_valid    <= s1_dec.char_valid;
      out_item.char_code     <= s1_dec.lookup ? rdata : 8'h00;
      out_item.led_bits      <= s1_dec.led_bits;
      out_item.led_update    <= s1_dec.led_update;
      out_item.reset_request <= s1_dec.reset_request;
    end
  end

  // A character, an LED change and a reset request never come together.
  `PS2SC_ASSERT_NOW(a_one_event, out_valid, $countones({out_item.char_valid, out_item.led_update, out_item.reset_request}) <= 1, "more than one event in a result")
  // No character means a zero code.
  `PS2SC_ASSERT_NOW(a_zero_code, out_valid && !out_item.char_valid, out_item.char_code == 8'h00, "nonzero code without character")
  // A table write never turns into a lookup.
  `PS2SC_ASSERT_NEXT(a_write_no_lookup, in_fire && in_item.mode == ps2sc_pkg::MODE_WRITE, s1_valid && !s1_dec.lookup && !s1_dec.char_valid, "table write decoded as lookup")
  // A stalled stage 1 blocks the input so its read data holds.
  `PS2SC_ASSERT_NOW(a_stall_interlock, s1_valid && !s1_adv, !in_ready, "input accepted over stalled read")

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`default_nettype none

module tb_top;

  // Random items after the directed part; the last TAIL_ITEMS go out with no idling.
  localparam int RAND_ITEMS     = 450;
  localparam int TAIL_ITEMS     = 80;
  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 500;
  // Cycles to watch for stray results once everything expected has come back.
  localparam int DRAIN_CYCLES   = 10;
  // Scancodes that a lookup may use; every one is loaded in all four tables.
  localparam int POOL_SIZE      = 19;

  typedef struct {
    ps2sc_pkg::in_item_t item;
    logic                drain;  // wait for all results before sending this one
  } stim_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  ps2sc_pkg::in_item_t  in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  ps2sc_pkg::out_item_t out_item;

  always #2 clk = ~clk;

  ps2_scancode_to_char_translator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  // ---------------------------------------------------------------------------
  // Keyboard state as the block should hold it, plus the four loaded tables.
  // ---------------------------------------------------------------------------
  logic       brk_seen;
  logic       ext_seen;
  logic [2:0] held_mods;
  logic [2:0] lock_state;
  logic [2:0] led_state;
  logic [7:0] char_map [4][ps2sc_pkg::TABLE_ENTRIES];

  // Results the block owes us, oldest first.
  ps2sc_pkg::out_item_t translated_q [$];
  stim_t                stim_q [$];

  int sent_cnt = 0;
  int recv_cnt = 0;
  int error_cnt = 0;
  int quiet_cycles = 0;
  logic quiet_tail = 1'b0;

  // Tallies for the closing summary.
  int n_chars = 0;
  int n_reboots = 0;
  int n_led_flips = 0;
  int n_writes = 0;

  // Set or clear a modifier; a pending break prefix turns the make into a release.
  function automatic void hold_modifier(input logic [2:0] mask);
    if (brk_seen) held_mods = held_mods & ~mask;
    else held_mods = held_mods | mask;
    brk_seen = 1'b0;
  endfunction

  // Toggle a lock on make only; a break just consumes the prefix.
  function automatic logic flip_lock(input logic [2:0] lock_mask, input logic [2:0] led_mask);
    if (brk_seen) begin
      brk_seen = 1'b0;
      return 1'b0;
    end
    lock_state = lock_state ^ lock_mask;
    led_state = led_state ^ led_mask;
    return 1'b1;
  endfunction

  // Advance the keyboard state by one transaction and queue the result it owes.
  function automatic void translate_item(input ps2sc_pkg::in_item_t it);
    ps2sc_pkg::out_item_t r;
    logic [7:0]           sc;
    r = '0;
    sc = it.scan_byte;
    if (it.mode == ps2sc_pkg::MODE_WRITE) begin
      char_map[it.table_select][sc] = it.table_data;
      n_writes++;
    end else if (sc == ps2sc_pkg::CODE_BREAK) begin
      brk_seen = 1'b1;
    end else if (sc == ps2sc_pkg::CODE_EXTEND) begin
      ext_seen = 1'b1;
    end else if (sc == ps2sc_pkg::CODE_CTRL) begin
      hold_modifier(ps2sc_pkg::MOD_CTRL);
    end else if (sc == ps2sc_pkg::CODE_SHIFT) begin
      hold_modifier(ps2sc_pkg::MOD_SHIFT);
    end else if (sc == ps2sc_pkg::CODE_ALT) begin
      hold_modifier(ps2sc_pkg::MOD_ALT);
    end else if (sc == ps2sc_pkg::CODE_NUM) begin
      r.led_update = flip_lock(ps2sc_pkg::LOCK_NUM, ps2sc_pkg::LED_NUM);
    end else if (sc == ps2sc_pkg::CODE_CAPS) begin
      r.led_update = flip_lock(ps2sc_pkg::LOCK_CAPS, ps2sc_pkg::LED_CAPS);
    end else if (sc == ps2sc_pkg::CODE_SCROLL) begin
      r.led_update = flip_lock(ps2sc_pkg::LOCK_SCROLL, ps2sc_pkg::LED_SCROLL);
    end else if (brk_seen) begin
      // released ordinary key: drop it
      brk_seen = 1'b0;
    end else if ((held_mods & ps2sc_pkg::MOD_CTRL_ALT) == ps2sc_pkg::MOD_CTRL_ALT &&
                 sc == ps2sc_pkg::CODE_DEL) begin
      r.reset_request = 1'b1;
      ext_seen = 1'b0;
    end else if (ext_seen) begin
      ext_seen = 1'b0;
      r.char_valid = 1'b1;
      r.char_code = char_map[ps2sc_pkg::TBL_EXT][sc];
    end else if ((held_mods & ps2sc_pkg::MOD_CTRL) != 0) begin
      r.char_valid = 1'b1;
      r.char_code = char_map[ps2sc_pkg::TBL_CTRL][sc];
    end else if ((held_mods & ps2sc_pkg::MOD_SHIFT) != 0) begin
      r.char_valid = 1'b1;
      r.char_code = char_map[ps2sc_pkg::TBL_SHIFT][sc];
    end else begin
      r.char_valid = 1'b1;
      r.char_code = char_map[ps2sc_pkg::TBL_PLAIN][sc];
    end
    r.led_bits = led_state;
    n_chars += r.char_valid;
    n_reboots += r.reset_request;
    n_led_flips += r.led_update;
    translated_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_cnt++;
    $display("[%0t] MISMATCH result %0d: %s", $realtime, recv_cnt, msg);
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building. Every transaction lands in stim_q before reset drops.
  // ---------------------------------------------------------------------------
  logic drain_next = 1'b0;

  task automatic push_item(input logic mode, input logic [7:0] sc,
                           input logic [1:0] sel, input logic [7:0] data);
    stim_t s;
    s.item.mode = mode;
    s.item.scan_byte = sc;
    s.item.table_select = sel;
    s.item.table_data = data;
    s.drain = drain_next;
    drain_next = 1'b0;
    stim_q.push_back(s);
  endtask

  // Scancode transaction; the unused write fields carry noise.
  task automatic push_scan(input logic [7:0] sc);
    push_item(ps2sc_pkg::MODE_SCAN, sc, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  task automatic push_write(input ps2sc_pkg::tbl_sel_t sel, input logic [7:0] idx,
                            input logic [7:0] data);
    push_item(ps2sc_pkg::MODE_WRITE, idx, sel, data);
  endtask

  // Full make (and optionally break) sequence of one key, with optional E0 prefix.
  task automatic push_key(input logic [7:0] sc, input logic ext, input logic release_too);
    if (ext) push_scan(ps2sc_pkg::CODE_EXTEND);
    push_scan(sc);
    if (release_too) begin
      if (ext) push_scan(ps2sc_pkg::CODE_EXTEND);
      push_scan(ps2sc_pkg::CODE_BREAK);
      push_scan(sc);
    end
  endtask

  // Sixteen codes spread over the whole byte range, then a few named ones.
  function automatic logic [7:0] pool_byte(input int k);
    if (k < 16) return 8'(k * 17);
    case (k)
      16:      return 8'h1C;
      17:      return ps2sc_pkg::CODE_DEL;
      default: return 8'h80;
    endcase
  endfunction

  function automatic logic [7:0] pick_key();
    return pool_byte($urandom_range(0, POOL_SIZE - 1));
  endfunction

  function automatic logic [7:0] pick_modifier();
    case ($urandom_range(0, 2))
      0:       return ps2sc_pkg::CODE_CTRL;
      1:       return ps2sc_pkg::CODE_SHIFT;
      default: return ps2sc_pkg::CODE_ALT;
    endcase
  endfunction

  function automatic logic [7:0] pick_lock();
    case ($urandom_range(0, 2))
      0:       return ps2sc_pkg::CODE_NUM;
      1:       return ps2sc_pkg::CODE_CAPS;
      default: return ps2sc_pkg::CODE_SCROLL;
    endcase
  endfunction

  function automatic logic [7:0] pick_prefix();
    return $urandom_range(0, 1) ? ps2sc_pkg::CODE_BREAK : ps2sc_pkg::CODE_EXTEND;
  endfunction

  task automatic build_directed();
    // Plain lookups at both index extremes, then a rewrite read straight back.
    drain_next = 1'b1;
    push_scan(8'h00);
    push_scan(8'hFF);
    push_write(ps2sc_pkg::TBL_PLAIN, 8'h00, 8'hFF);
    push_write(ps2sc_pkg::TBL_PLAIN, 8'hFF, 8'h00);
    push_scan(8'h00);
    push_scan(8'hFF);
    // Extended prefix selects the extended table once.
    push_key(8'hFF, 1'b1, 1'b0);
    // Ctrl beats shift; releasing ctrl falls back to the shifted table.
    push_scan(ps2sc_pkg::CODE_CTRL);
    push_scan(ps2sc_pkg::CODE_SHIFT);
    push_scan(8'h80);
    push_key(ps2sc_pkg::CODE_CTRL, 1'b0, 1'b1);
    push_scan(8'h80);
    // Num lock make and release (the release must not toggle), then caps and scroll lock make.
    push_key(ps2sc_pkg::CODE_NUM, 1'b0, 1'b1);
    push_scan(ps2sc_pkg::CODE_CAPS);
    push_scan(ps2sc_pkg::CODE_SCROLL);
    // Released ordinary key gives nothing.
    push_scan(ps2sc_pkg::CODE_BREAK);
    push_scan(8'h1C);
    // Ctrl+Alt+Del plain and with the extend prefix.
    push_scan(ps2sc_pkg::CODE_CTRL);
    push_scan(ps2sc_pkg::CODE_ALT);
    push_scan(ps2sc_pkg::CODE_DEL);
    push_key(ps2sc_pkg::CODE_DEL, 1'b1, 1'b0);
  endtask

  task automatic build_random();
    int base;
    int next_drain;
    int pick;
    base = stim_q.size();
    next_drain = 120;
    while (stim_q.size() < base + RAND_ITEMS) begin
      // Pause now and then until the block has answered everything.
      if (stim_q.size() - base >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 150;
      end
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        push_key(pick_key(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0);
      end else if (pick < 47) begin
        // right ctrl and alt arrive with the extend prefix
        push_key(pick_modifier(), $urandom_range(0, 3) == 0, $urandom_range(0, 1) == 0);
      end else if (pick < 56) begin
        push_key(pick_lock(), 1'b0, $urandom_range(0, 2) != 0);
      end else if (pick < 64) begin
        push_scan(ps2sc_pkg::CODE_CTRL);
        push_key(ps2sc_pkg::CODE_ALT, $urandom_range(0, 1) == 0, 1'b0);
        push_key(ps2sc_pkg::CODE_DEL, $urandom_range(0, 1) == 0, 1'b1);
        if ($urandom_range(0, 1) == 0) push_key(ps2sc_pkg::CODE_ALT, 1'b0, 1'b1);
        if ($urandom_range(0, 1) == 0) push_key(ps2sc_pkg::CODE_CTRL, 1'b0, 1'b1);
      end else if (pick < 74) begin
        push_write(ps2sc_pkg::tbl_sel_t'($urandom_range(0, 3)), pick_key(),
                   8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        // lone byte, prefixes included
        push_scan($urandom_range(0, 4) == 0 ? pick_prefix() : pick_key());
      end else begin
        // broken sequence: stray prefix straight into another prefix or key
        push_scan(pick_prefix());
        push_scan(pick_prefix());
        push_scan(pick_key());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present one transaction at a time, hold it until accepted.
  // ---------------------------------------------------------------------------
  int   send_gap = 0;
  int   send_phase_left = 0;
  logic send_idle_on = 1'b1;

  always @(posedge clk) begin
    stim_t nxt;
    logic  took;
    logic  got;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      got = out_valid && out_ready;
      if (took) begin
        translate_item(in_item);
        sent_cnt <= sent_cnt + 1;
      end
      // Alternate stretches with and without idling.
      if (send_phase_left == 0) begin
        send_phase_left = $urandom_range(16, 96);
        send_idle_on = $urandom_range(0, 2) != 0;
      end else begin
        send_phase_left--;
      end
      quiet_tail <= stim_q.size() < TAIL_ITEMS;
      if (took || !in_valid) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (stim_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (stim_q[0].drain && (sent_cnt + took != recv_cnt + got)) begin
          // hold until every owed result is back
          in_valid <= 1'b0;
        end else if (!quiet_tail && send_idle_on && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          nxt = stim_q.pop_front();
          in_valid <= 1'b1;
          in_item <= nxt.item;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest owed one, stall at random.
  // ---------------------------------------------------------------------------
  int   recv_gap = 0;
  int   recv_phase_left = 0;
  logic recv_idle_on = 1'b1;

  always @(posedge clk) begin
    ps2sc_pkg::out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        recv_cnt <= recv_cnt + 1;
        if (translated_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result 0x%0h", out_item));
        end else begin
          want = translated_q.pop_front();
          compare_field("char_valid", 8'(out_item.char_valid), 8'(want.char_valid));
          compare_field("char_code", out_item.char_code, want.char_code);
          compare_field("led_bits", 8'(out_item.led_bits), 8'(want.led_bits));
          compare_field("led_update", 8'(out_item.led_update), 8'(want.led_update));
          compare_field("reset_request", 8'(out_item.reset_request),
                        8'(want.reset_request));
        end
      end
      if (recv_phase_left == 0) begin
        recv_phase_left = $urandom_range(16, 96);
        recv_idle_on = $urandom_range(0, 2) != 0;
      end else begin
        recv_phase_left--;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!quiet_tail && recv_idle_on && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Sequencing: load the tables, build stimulus, release reset, wait, judge.
  // ---------------------------------------------------------------------------
  initial begin
    int total;
    brk_seen = 1'b0;
    ext_seen = 1'b0;
    held_mods = '0;
    lock_state = '0;
    led_state = '0;
    // Fill every entry a lookup can reach first, so none touches an unwritten one.
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < POOL_SIZE; k++) begin
        push_write(ps2sc_pkg::tbl_sel_t'(s), pool_byte(k), 8'($urandom_range(0, 255)));
      end
    end
    build_directed();
    build_random();
    total = stim_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (!(stim_q.size() == 0 && !in_valid && sent_cnt == recv_cnt)
           && quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
    end

    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", quiet_cycles);
      $display("Mismatches found");
    end else begin
      // Watch for stray results after the last owed one.
      repeat (DRAIN_CYCLES) @(negedge clk);
      if (translated_q.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", translated_q.size()));
      $display("Sent %0d transactions (%0d table writes), checked %0d results",
               total, n_writes, recv_cnt);
      $display("Saw %0d characters, %0d reboot requests, %0d LED toggles",
               n_chars, n_reboots, n_led_flips);
      if (error_cnt == 0) begin
        $display("No mismatches found");
      end else begin
        $display("Mismatches found");
      end
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/ps2sc_pkg.sv
rtl/ps2sc_table_ram.sv
rtl/ps2sc_key_decode.sv
rtl/ps2_scancode_to_char_translator_unit.sv
verif/tb_top.sv
